>>> rtl/button_debounce_press_classifier_macros.svh
// assertion macros shared by the button debounce and press classifier rtl
// no dependencies; included by the files that hold assertions
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_MACROS_SVH

// consequent must hold at the same edge as the antecedent
`define BDPC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold at the edge after the antecedent
`define BDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bdpc_pkg.sv
// shared types and constants for the button debounce and press classifier
// no dependencies
package bdpc_pkg;

	// fixed field widths
	localparam int TIME_W    = 32;
	localparam int CFG_W     = 16;
	localparam int PIN_COUNT = 3;
	localparam int IDX_W     = 2;
	localparam int CFG_IDX_W = 1;

	// default number of buttons
	localparam int BUTTONS_DEF = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'b1;

	// register reset values
	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

	// level codes (active low pins)
	localparam logic LVL_PRESSED  = 1'b0;
	localparam logic LVL_RELEASED = 1'b1;

	// what one button lane reports for the current poll
	typedef struct packed {
		logic fire;
		logic long_press;
	} lane_evt_t;

endpackage

>>> rtl/bdpc_ifs.sv
// request channels of the button debounce and press classifier
// depends on bdpc_pkg for field widths
interface bdpc_poll_if;
	logic                          valid;
	logic                          ready;
	logic [bdpc_pkg::TIME_W-1:0]    now_ms;
	logic [bdpc_pkg::PIN_COUNT-1:0] raw_levels;

	modport source (output valid, output now_ms, output raw_levels, input ready);
	modport sink   (input valid, input now_ms, input raw_levels, output ready);
endinterface

interface bdpc_result_if;
	logic                      valid;
	logic                      ready;
	logic                      event_valid;
	logic [bdpc_pkg::IDX_W-1:0] button_index;
	logic                      long_press;

	modport source (output valid, output event_valid, output button_index,
		output long_press, input ready);
	modport sink   (input valid, input event_valid, input button_index,
		input long_press, output ready);
endinterface

>>> rtl/button_debounce_press_classifier.sv
// Button debounce and short/long press classifier, top level.
// Depends on bdpc_pkg, bdpc_ifs, bdpc_lane and the macros header.
//
// Usage:
// - poll (sink): one request per poll, carrying now_ms, a wrapping
//   millisecond timestamp, and raw_levels, the active-low button pins.
// - result (source): exactly one request per poll: event_valid, and for an
//   event the released button_index and long_press (1 long, 0 short).
// - cfg_we / cfg_index / cfg_wdata: register writes, index 0 debounce
//   time, index 1 long-press time, both in milliseconds; write while idle.
// Timing: a poll is registered in the input register at acceptance, and its
// result is registered in the result register when the input stage advances,
// which waits while the result register is full and not being taken.
// One poll per cycle is sustained while results are taken as offered; the
// path is a per-button subtract and compare, then a lowest-index priority pick.
// Reset: all buttons released with no press recorded, registers at their
// defaults (50 and 1000), both channels empty.
// Stall: while the result is not taken, the result register holds and the
// input register keeps one further poll; poll.ready then drops.
`include "button_debounce_press_classifier_macros.svh"

module button_debounce_press_classifier #(
	parameter int BUTTONS = bdpc_pkg::BUTTONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bdpc_poll_if.sink                       poll,
	bdpc_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0]      cfg_wdata
);

	logic [bdpc_pkg::CFG_W-1:0]     debounce_q;
	logic [bdpc_pkg::CFG_W-1:0]     long_press_q;

	logic                           valid_s1;
	logic [bdpc_pkg::TIME_W-1:0]    now_ms_s1;
	logic [bdpc_pkg::PIN_COUNT-1:0] raw_levels_s1;

	logic                           result_valid_q;
	logic                           event_valid_q;
	logic [bdpc_pkg::IDX_W-1:0]     button_index_q;
	logic                           long_flag_q;

	logic                           advance;
	logic [BUTTONS-1:0]             lane_lvl;
	logic [BUTTONS-1:0]             lane_fire;
	logic [BUTTONS-1:0]             lane_long;
	logic [BUTTONS-1:0]             blocked;
	logic [BUTTONS-1:0]             fire_taken;
	bdpc_pkg::lane_evt_t            lane_evt [BUTTONS];

	logic                           event_d;
	logic [bdpc_pkg::IDX_W-1:0]     index_d;
	logic                           long_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bdpc_pkg::DEBOUNCE_RST;
			long_press_q <= bdpc_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdpc_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_wdata;
				bdpc_pkg::REG_LONG_PRESS: long_press_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the result slot is free or emptying
	assign advance    = valid_s1 && (!result_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			now_ms_s1     <= poll.now_ms;
			raw_levels_s1 <= poll.raw_levels;
		end
	end

	// button lanes; buttons with no pin read as released
	for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
		if (b < bdpc_pkg::PIN_COUNT) begin : g_pin
			assign lane_lvl[b] = raw_levels_s1[b];
		end else begin : g_nopin
			assign lane_lvl[b] = bdpc_pkg::LVL_RELEASED;
		end

		bdpc_lane u_lane (
			.clk             (clk),
			.arst_n          (arst_n),
			.step            (advance && !blocked[b]),
			.lvl             (lane_lvl[b]),
			.now_ms          (now_ms_s1),
			.debounce_time   (debounce_q),
			.long_press_time (long_press_q),
			.evt             (lane_evt[b])
		);

		assign lane_fire[b] = lane_evt[b].fire;
		assign lane_long[b] = lane_evt[b].long_press;
	end

	// lowest-index event wins and freezes the buttons above it
	always_comb begin
		blocked[0] = 1'b0;
		for (int b = 1; b < BUTTONS; b++) begin
			blocked[b] = blocked[b-1] | lane_fire[b-1];
		end
		fire_taken = lane_fire & ~blocked;
		event_d    = |lane_fire;
		index_d    = '0;
		long_d     = 1'b0;
		for (int b = 0; b < BUTTONS; b++) begin
			if (fire_taken[b]) begin
				index_d = bdpc_pkg::IDX_W'(b);
				long_d  = lane_long[b];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_valid_q  <= event_d;
			button_index_q <= index_d;
			long_flag_q    <= long_d;
		end
	end

	assign result.valid        = result_valid_q;
	assign result.event_valid  = event_valid_q;
	assign result.button_index = button_index_q;
	assign result.long_press   = long_flag_q;

	// checks
	`BDPC_ASSERT_SAME(a_one_winner, clk, arst_n, valid_s1, $onehot0(fire_taken), "two buttons won")
	`BDPC_ASSERT_NEXT(a_adv_fills, clk, arst_n, advance, result_valid_q, "result lost")
	`BDPC_ASSERT_NEXT(a_evt_carried, clk, arst_n, advance && event_d, event_valid_q, "event lost")
	`BDPC_ASSERT_SAME(a_stall_full, clk, arst_n, !poll.ready, valid_s1 && result_valid_q && !result.ready, "needless stall")

endmodule

>>> rtl/bdpc_lane.sv
// one button: debounce state, press timing and release classification
// depends on bdpc_pkg
module bdpc_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         lvl,
	input  logic [bdpc_pkg::TIME_W-1:0]  now_ms,
	input  logic [bdpc_pkg::CFG_W-1:0]   debounce_time,
	input  logic [bdpc_pkg::CFG_W-1:0]   long_press_time,
	output bdpc_pkg::lane_evt_t          evt
);

	logic                        prev_raw_q;
	logic                        stable_q;
	logic                        held_q;
	logic [bdpc_pkg::TIME_W-1:0] change_time_q;
	logic [bdpc_pkg::TIME_W-1:0] press_start_q;

	logic                        raw_changed;
	logic [bdpc_pkg::TIME_W-1:0] change_time_d;
	logic [bdpc_pkg::TIME_W-1:0] settle_elapsed;
	logic [bdpc_pkg::TIME_W-1:0] hold_time;
	logic                        settled;
	logic                        stable_chg;
	logic                        press_start;
	logic                        release_evt;

	// debounce window and level acceptance
	always_comb begin
		raw_changed    = (lvl != prev_raw_q);
		change_time_d  = raw_changed ? now_ms : change_time_q;
		settle_elapsed = now_ms - change_time_d;
		settled        = (settle_elapsed >=
			{{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, debounce_time});
		stable_chg     = settled && (lvl != stable_q);
		press_start    = stable_chg && (lvl == bdpc_pkg::LVL_PRESSED);
		release_evt    = stable_chg && (lvl == bdpc_pkg::LVL_RELEASED) && held_q;
		hold_time      = now_ms - press_start_q;
	end

	// event for this poll
	always_comb begin
		evt.fire       = release_evt;
		evt.long_press = (hold_time >=
			{{(bdpc_pkg::TIME_W-bdpc_pkg::CFG_W){1'b0}}, long_press_time});
	end

	// state update, only when this button takes part in the poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q    <= bdpc_pkg::LVL_RELEASED;
			stable_q      <= bdpc_pkg::LVL_RELEASED;
			held_q        <= 1'b0;
			change_time_q <= '0;
			press_start_q <= '0;
		end else if (step) begin
			prev_raw_q    <= lvl;
			change_time_q <= change_time_d;
			if (stable_chg) begin
				stable_q <= lvl;
			end
			if (press_start) begin
				held_q        <= 1'b1;
				press_start_q <= now_ms;
			end else if (release_evt) begin
				held_q <= 1'b0;
			end
		end
	end

endmodule

>>> sim/press_event_checker.sv
// press event checker: watches the poll and result channels and the register port
// keeps its own debounce and press timing state; depends on bdpc_pkg and bdpc_ifs
`timescale 1ns / 100ps

module press_event_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	bdpc_poll_if                           poll,
	bdpc_result_if                         result,
	input  logic                           cfg_we,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bdpc_pkg::CFG_W-1:0]     cfg_wdata,
	output int                             mismatches,
	output int                             pending
);

	typedef struct packed {
		logic                       fire;
		logic [bdpc_pkg::IDX_W-1:0] btn;
		logic                       lng;
	} release_event_t;

	// timing registers as last written
	logic [bdpc_pkg::CFG_W-1:0] debounce_ms;
	logic [bdpc_pkg::CFG_W-1:0] long_ms;

	// per button debounce and hold state
	logic                        raw_seen  [bdpc_pkg::PIN_COUNT];
	logic                        settled   [bdpc_pkg::PIN_COUNT];
	logic [bdpc_pkg::TIME_W-1:0] change_at [bdpc_pkg::PIN_COUNT];
	logic [bdpc_pkg::TIME_W-1:0] press_at  [bdpc_pkg::PIN_COUNT];
	logic                        armed     [bdpc_pkg::PIN_COUNT];

	release_event_t expected_events[$];
	release_event_t predicted;
	release_event_t want;
	int             err_total;

	// one poll through every button in index order; the first release ends it
	task automatic predict_release_event(input logic [bdpc_pkg::TIME_W-1:0] now,
		input logic [bdpc_pkg::PIN_COUNT-1:0] pins, output release_event_t ev);
		logic                        lvl;
		logic [bdpc_pkg::TIME_W-1:0] since;
		logic [bdpc_pkg::TIME_W-1:0] hold;
		bit                          found;
		ev = '0;
		found = 1'b0;
		for (int b = 0; b < bdpc_pkg::PIN_COUNT && !found; b++) begin
			lvl = pins[b];
			if (lvl != raw_seen[b]) begin
				raw_seen[b] = lvl;
				change_at[b] = now;
			end
			since = now - change_at[b];
			if (since >= {16'd0, debounce_ms} && lvl != settled[b]) begin
				settled[b] = lvl;
				if (lvl == bdpc_pkg::LVL_PRESSED) begin
					armed[b] = 1'b1;
					press_at[b] = now;
				end else if (armed[b]) begin
					hold = now - press_at[b];
					armed[b] = 1'b0;
					ev.fire = 1'b1;
					ev.btn = bdpc_pkg::IDX_W'(b);
					ev.lng = (hold >= {16'd0, long_ms});
					found = 1'b1;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ms = bdpc_pkg::DEBOUNCE_RST;
			long_ms = bdpc_pkg::LONG_PRESS_RST;
			for (int b = 0; b < bdpc_pkg::PIN_COUNT; b++) begin
				raw_seen[b] = bdpc_pkg::LVL_RELEASED;
				settled[b] = bdpc_pkg::LVL_RELEASED;
				change_at[b] = '0;
				press_at[b] = '0;
				armed[b] = 1'b0;
			end
			expected_events.delete();
			err_total = 0;
			pending <= 0;
			mismatches <= 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					bdpc_pkg::REG_DEBOUNCE:   debounce_ms = cfg_wdata;
					bdpc_pkg::REG_LONG_PRESS: long_ms = cfg_wdata;
					default: ;
				endcase
			end
			// accepted poll request: work out its result
			if (poll.valid && poll.ready) begin
				predict_release_event(poll.now_ms, poll.raw_levels, predicted);
				expected_events.push_back(predicted);
			end
			// accepted result request: compare with the oldest prediction
			if (result.valid && result.ready) begin
				if (expected_events.size() == 0) begin
					err_total++;
					$display("%0t: unexpected result: expected none, got %0b/%0d/%0b",
						$time, result.event_valid, result.button_index, result.long_press);
				end else begin
					want = expected_events.pop_front();
					if (result.event_valid !== want.fire || result.button_index !== want.btn ||
						result.long_press !== want.lng) begin
						err_total++;
						$display("%0t: result mismatch: expected %0b/%0d/%0b, got %0b/%0d/%0b",
							$time, want.fire, want.btn, want.lng,
							result.event_valid, result.button_index, result.long_press);
					end
				end
			end
			pending <= expected_events.size();
			mismatches <= err_total;
		end
	end

endmodule

>>> sim/tb.sv
// top level bench for the button debounce and press classifier
// drives polls, register writes and result stalls; press_event_checker does the checking
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POLL_TOTAL  = 550;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bdpc_pkg::CFG_W-1:0]     cfg_wdata;

	int          mismatches;
	int          pending;
	int          cycle_count = 0;
	int          polls_sent;
	int          idle_pct;
	int          stall_pct;
	int unsigned cur_db;
	int unsigned cur_lp;
	logic [bdpc_pkg::TIME_W-1:0] ms_now;

	bdpc_poll_if   poll_ch ();
	bdpc_result_if result_ch ();

	button_debounce_press_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	press_event_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.poll       (poll_ch),
		.result     (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("button_debounce_press_classifier test failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		result_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
	end

	// one poll request, with random idle cycles ahead of it
	task automatic send_poll(input logic [bdpc_pkg::TIME_W-1:0] stamp,
		input logic [bdpc_pkg::PIN_COUNT-1:0] pins);
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			poll_ch.valid <= 1'b0;
			@(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.now_ms <= stamp;
		poll_ch.raw_levels <= pins;
		@(posedge clk);
		while (!poll_ch.ready) @(posedge clk);
		polls_sent++;
	endtask

	// stop polling and wait until every result is back
	task automatic drain();
		poll_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both timing registers, on consecutive edges
	task automatic set_timing(input logic [bdpc_pkg::CFG_W-1:0] db,
		input logic [bdpc_pkg::CFG_W-1:0] lp);
		cfg_we <= 1'b1;
		cfg_index <= bdpc_pkg::REG_DEBOUNCE;
		cfg_wdata <= db;
		@(posedge clk);
		cfg_index <= bdpc_pkg::REG_LONG_PRESS;
		cfg_wdata <= lp;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_db = 32'(db);
		cur_lp = 32'(lp);
	endtask

	// a press of some buttons with bounce, a hold near the long threshold and a release
	task automatic press_and_release();
		logic [bdpc_pkg::PIN_COUNT-1:0] mask;
		logic [bdpc_pkg::TIME_W-1:0]    t0;
		logic [bdpc_pkg::TIME_W-1:0]    t_rel;
		int unsigned                    h;
		mask = bdpc_pkg::PIN_COUNT'($urandom_range(1, 7));
		// contact bounce
		if ($urandom_range(0, 1)) begin
			repeat ($urandom_range(1, 3)) begin
				ms_now = ms_now + $urandom_range(0, cur_db / 2 + 1);
				send_poll(ms_now, bdpc_pkg::PIN_COUNT'($urandom_range(0, 7)));
			end
		end
		t0 = ms_now + $urandom_range(1, 8);
		send_poll(t0, ~mask);
		if ($urandom_range(0, 1))
			send_poll(t0 + $urandom_range(0, cur_db), ~mask);
		send_poll(t0 + cur_db, ~mask);
		// hold length around the long press threshold
		case ($urandom_range(0, 3))
			0:       h = (cur_lp != 0) ? cur_lp - 1 : 0;
			1:       h = cur_lp;
			2:       h = cur_lp + 1;
			default: h = $urandom_range(0, 2 * cur_lp + 2);
		endcase
		if (h < cur_db)
			h = cur_db;
		repeat ($urandom_range(0, 2))
			send_poll(t0 + cur_db + $urandom_range(0, h - cur_db), ~mask);
		// release, then flush the remaining buttons one per poll
		send_poll(t0 + h, '1);
		t_rel = t0 + h + cur_db;
		send_poll(t_rel, '1);
		repeat (2)
			send_poll(t_rel + $urandom_range(0, 4), '1);
		ms_now = t_rel + 8;
	endtask

	// random levels at a random or wildly jumping timestamp
	task automatic stray_poll();
		logic [bdpc_pkg::TIME_W-1:0] stamp;
		if ($urandom_range(0, 3) == 0) begin
			stamp = $urandom;
		end else begin
			ms_now = ms_now + $urandom_range(0, 2 * cur_db + 2);
			stamp = ms_now;
		end
		send_poll(stamp, bdpc_pkg::PIN_COUNT'($urandom_range(0, 7)));
	endtask

	initial begin
		int target;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= bdpc_pkg::REG_DEBOUNCE;
		cfg_wdata <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.now_ms <= '0;
		poll_ch.raw_levels <= '1;
		idle_pct = 0;
		stall_pct = 0;
		polls_sent = 0;
		cur_db = 32'(bdpc_pkg::DEBOUNCE_RST);
		cur_lp = 32'(bdpc_pkg::LONG_PRESS_RST);
		ms_now = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default timing: field extremes, wrap of the timestamp, all buttons at once
		send_poll(32'd0, 3'b111);
		send_poll(32'hFFFF_FFFF, 3'b000);
		send_poll(32'd49, 3'b000);
		send_poll(32'd1049, 3'b111);
		send_poll(32'd1099, 3'b111);
		send_poll(32'd1099, 3'b111);
		send_poll(32'd1100, 3'b111);
		// timestamp going backwards, then a short press
		send_poll(32'd5000, 3'b110);
		send_poll(32'd4000, 3'b110);
		send_poll(32'd4500, 3'b111);
		send_poll(32'd4550, 3'b111);
		drain();

		// zero debounce and zero long press time
		set_timing(16'd0, 16'd0);
		send_poll(32'd10, 3'b101);
		send_poll(32'd10, 3'b111);
		drain();

		// zero debounce, longest threshold: one short of it and right on it
		set_timing(16'd0, 16'hFFFF);
		send_poll(32'd20, 3'b011);
		send_poll(32'd65554, 3'b111);
		send_poll(32'd30, 3'b110);
		send_poll(32'd65565, 3'b111);
		drain();

		// random phases over timing settings and idling patterns
		ms_now = 32'hFFFF_0000;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_timing(16'd0, 16'd0);
				1: set_timing(16'hFFFF, 16'hFFFF);
				2: set_timing(16'd3, 16'd25);
				3: set_timing(bdpc_pkg::DEBOUNCE_RST, bdpc_pkg::LONG_PRESS_RST);
				4: set_timing(16'd1, 16'hFFFF);
				5: set_timing(bdpc_pkg::CFG_W'($urandom_range(0, 400)),
					bdpc_pkg::CFG_W'($urandom_range(0, 3000)));
				6: set_timing(bdpc_pkg::CFG_W'($urandom_range(0, 65535)),
					bdpc_pkg::CFG_W'($urandom_range(0, 65535)));
				default: set_timing(bdpc_pkg::CFG_W'($urandom_range(0, 20)),
					bdpc_pkg::CFG_W'($urandom_range(0, 200)));
			endcase
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 58; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 58; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			target = (POLL_TOTAL * (p + 1)) / 8;
			while (polls_sent < target) begin
				if ($urandom_range(0, 4) == 0)
					stray_poll();
				else
					press_and_release();
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("button_debounce_press_classifier test passed");
		else
			$display("button_debounce_press_classifier test failed");
		$finish;
	end

endmodule
